FILE: rtl/sliding_window_price_channel_unit_defines.svh
// ---------------------------------------------------------------------------
// sliding window price channel assertion macros
// shared property forms for the checker, sampled on clk, off during rst
// ---------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_PRICE_CHANNEL_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_PRICE_CHANNEL_UNIT_DEFINES_SVH

// same-cycle implication
`define SWPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SWPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/swpc_pkg.sv
// ---------------------------------------------------------------------------
// swpc_pkg
// shared types and constants of the sliding window price channel
// ---------------------------------------------------------------------------
package swpc_pkg;

  localparam int FIELD_W  = 32;
  localparam int WINDOW_W = 7;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(10);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } swpc_state_t;

  // control from the sequencer to the min/max unit
  typedef struct packed {
    logic init;
    logic step;
  } swpc_acc_ctl_t;

endpackage

FILE: rtl/swpc_if.sv
// ---------------------------------------------------------------------------
// swpc channel interfaces
// valid/ready channels for price bars in and channel bands out
// ---------------------------------------------------------------------------
interface swpc_bar_if import swpc_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] high_price;
  logic [FIELD_W-1:0] low_price;
  logic [FIELD_W-1:0] sample_time;
  logic               restart;

  modport source (output valid, high_price, low_price, sample_time, restart, input ready);
  modport sink   (input valid, high_price, low_price, sample_time, restart, output ready);
endinterface

interface swpc_band_if import swpc_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] top_band;
  logic [FIELD_W-1:0] bottom_band;
  logic [FIELD_W-1:0] band_time;

  modport source (output valid, top_band, bottom_band, band_time, input ready);
  modport sink   (input valid, top_band, bottom_band, band_time, output ready);
endinterface

FILE: rtl/sliding_window_price_channel_unit.sv
// ---------------------------------------------------------------------------
// sliding_window_price_channel_unit
// donchian price channel over the newest window_periods price bars
// ---------------------------------------------------------------------------
// Each accepted bar is written to a ring of MAX_WINDOW {high, low} pairs in one
// ram. A bar that does not complete the window leaves the block ready again in
// the next cycle. Otherwise the block scans the newest w entries (w is the
// window size, 0 read as 1 and clipped to MAX_WINDOW) through the ram's single
// read port, one entry per cycle into a shared max/min compare unit, and holds
// ready low through the scan and until the result is loaded into the output
// register, so a bar with a result waits on the scan through the one read port.
// The result waits in an output register, and the next bar can be accepted
// while it does; a bar whose scan ends while an earlier result still waits
// keeps ready low until that earlier result transfers. Ring contents are not
// cleared at reset; only stored bars of the current series are ever read.
module sliding_window_price_channel_unit import swpc_pkg::*; #(
  parameter int MAX_WINDOW = 64,
  parameter int PRICE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  swpc_bar_if.sink            bar_in,
  swpc_band_if.source         band_out,
  input  logic                cfg_we,
  input  logic [WINDOW_W-1:0] cfg_wdata
);

  localparam int ADDR_W = $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W  = (CNT_W > WINDOW_W) ? CNT_W : WINDOW_W;
  localparam int RAM_W  = 2 * PRICE_BITS;
  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(MAX_WINDOW - 1);
  localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_WINDOW);

  swpc_state_t         state, state_next;
  logic [WINDOW_W-1:0] window_periods;
  logic [ADDR_W-1:0]   write_slot;
  logic [CNT_W-1:0]    fill_count;
  logic [CNT_W-1:0]    win;
  logic [ADDR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]    issue_cnt;
  logic                pend;
  logic [FIELD_W-1:0]  time_q;
  logic                out_valid;
  logic [FIELD_W-1:0]  top_q, bottom_q, band_time_q;

  logic                  accept;
  logic                  issue;
  logic                  load_out;
  swpc_acc_ctl_t         acc_ctl;
  logic [CNT_W-1:0]      win_eff;
  logic [ADDR_W-1:0]     slot_inc;
  logic [CNT_W-1:0]      fill_base, fill_inc;
  logic [PRICE_BITS-1:0] hi_in, lo_in;
  logic [RAM_W-1:0]      rd_data;
  logic [PRICE_BITS-1:0] top, bottom;

  // size casts truncate or zero-extend to the stored price width
  assign hi_in = PRICE_BITS'(bar_in.high_price);
  assign lo_in = PRICE_BITS'(bar_in.low_price);

  always_comb begin
    if (window_periods == '0) begin
      win_eff = CNT_W'(1);
    end else if (CMP_W'(window_periods) > CMP_W'(MAX_WINDOW)) begin
      win_eff = MAX_CNT;
    end else begin
      win_eff = CNT_W'(window_periods);
    end
  end

  assign slot_inc  = (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
  // restart drops the count before this bar is counted
  assign fill_base = bar_in.restart ? '0 : fill_count;
  assign fill_inc  = (fill_base == MAX_CNT) ? fill_base : fill_base + 1'b1;

  assign bar_in.ready = (state == ST_IDLE);
  assign accept       = bar_in.valid && bar_in.ready;

  always_comb begin
    state_next   = state;
    issue        = 1'b0;
    load_out     = 1'b0;
    acc_ctl      = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          acc_ctl.init = 1'b1;
          if (fill_inc >= win_eff) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        issue        = (issue_cnt != win);
        acc_ctl.step = pend;
        if (!issue && !pend) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        load_out = !out_valid || band_out.ready;
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_periods <= WINDOW_RESET;
      write_slot     <= '0;
      fill_count     <= '0;
      win            <= CNT_W'(1);
      rd_ptr         <= '0;
      issue_cnt      <= '0;
      pend           <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_periods <= cfg_wdata;
      end
      if (accept) begin
        write_slot <= slot_inc;
        fill_count <= fill_inc;
        win        <= win_eff;
        rd_ptr     <= slot_inc;
        issue_cnt  <= '0;
      end else if (issue) begin
        // walk back from the newest slot
        rd_ptr    <= (rd_ptr == '0) ? LAST_SLOT : rd_ptr - 1'b1;
        issue_cnt <= issue_cnt + 1'b1;
      end
      pend <= issue;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (band_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      time_q <= bar_in.sample_time;
    end
    if (load_out) begin
      top_q       <= FIELD_W'(top);
      bottom_q    <= FIELD_W'(bottom);
      band_time_q <= time_q;
    end
  end

  swpc_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (accept),
    .waddr (slot_inc),
    .wdata ({hi_in, lo_in}),
    .re    (issue),
    .raddr (rd_ptr),
    .rdata (rd_data)
  );

  swpc_minmax #(
    .PRICE_BITS (PRICE_BITS)
  ) u_minmax (
    .clk     (clk),
    .ctl     (acc_ctl),
    .high_in (rd_data[RAM_W-1:PRICE_BITS]),
    .low_in  (rd_data[PRICE_BITS-1:0]),
    .top     (top),
    .bottom  (bottom)
  );

  assign band_out.valid       = out_valid;
  assign band_out.top_band    = top_q;
  assign band_out.bottom_band = bottom_q;
  assign band_out.band_time   = band_time_q;

endmodule

FILE: rtl/swpc_ram.sv
// ---------------------------------------------------------------------------
// swpc_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module swpc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/swpc_minmax.sv
// ---------------------------------------------------------------------------
// swpc_minmax
// running maximum of highs and minimum of lows, one stored pair per step
// ---------------------------------------------------------------------------
module swpc_minmax import swpc_pkg::*; #(
  parameter int PRICE_BITS = 32
) (
  input  logic                  clk,
  input  swpc_acc_ctl_t         ctl,
  input  logic [PRICE_BITS-1:0] high_in,
  input  logic [PRICE_BITS-1:0] low_in,
  output logic [PRICE_BITS-1:0] top,
  output logic [PRICE_BITS-1:0] bottom
);

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      top    <= '0;
      bottom <= '1;
    end else if (ctl.step) begin
      if (high_in > top) begin
        top <= high_in;
      end
      if (low_in < bottom) begin
        bottom <= low_in;
      end
    end
  end

endmodule

FILE: rtl/swpc_checker.sv
// ---------------------------------------------------------------------------
// swpc_checker
// port-level checks of the price channel, bound to the top level
// ---------------------------------------------------------------------------
`include "sliding_window_price_channel_unit_defines.svh"

module swpc_checker import swpc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [FIELD_W-1:0] out_top,
  input logic [FIELD_W-1:0] out_bottom,
  input logic [FIELD_W-1:0] out_time
);

  // a stalled result keeps its payload
  `SWPC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_top) && $stable(out_bottom) && $stable(out_time), "band result changed while stalled")

  // a new result comes out of the scan, when no bar can be taken
  `SWPC_ASSERT_IMP(a_result_busy, $rose(out_valid), !$past(in_ready), "result appeared while input was ready")

  // the scan needs at least a read and a compare after the accepting edge
  `SWPC_ASSERT_IMP(a_result_latency, $rose(out_valid), !$past(in_valid && in_ready, 1) && !$past(in_valid && in_ready, 2), "result too soon after bar transfer")

endmodule

bind sliding_window_price_channel_unit swpc_checker u_swpc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (bar_in.valid),
  .in_ready   (bar_in.ready),
  .out_valid  (band_out.valid),
  .out_ready  (band_out.ready),
  .out_top    (band_out.top_band),
  .out_bottom (band_out.bottom_band),
  .out_time   (band_out.band_time)
);
